@@ hw/rtl/ifmt_pkg.sv @@
// Shared types, character codes and helpers for the integer field formatter.
// Used by ifmt_div_unit and integer_field_formatter; no dependencies.
package ifmt_pkg;

   // Digit store depth and index width
   localparam int DIGIT_DEPTH = 11;
   localparam int DIGIT_IDX_W = $clog2(DIGIT_DEPTH);

   // Largest precision honored; larger requests saturate
   localparam logic [5:0] MAX_PREC = 6'd62;

   // Reciprocal of ten for a 32-bit dividend: q = (x * RECIP_TEN) >> 35
   localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   // ASCII codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_A     = 8'h61;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // Conversion kinds (req_tuser)
   localparam logic FUNC_DEC = 1'b0;
   localparam logic FUNC_HEX = 1'b1;

   // One step of the shared divide unit: quotient and digit
   typedef struct packed {
      logic [31:0] quot;
      logic [3:0]  digit;
   } div_result_type;

   // Digit value to lowercase ASCII
   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + {4'd0, d};
      end else begin
         c = CHAR_A + {4'd0, d} - 8'd10;
      end
      return c;
   endfunction

endpackage

@@ hw/rtl/ifmt_div_unit.sv @@
// Shared divide-by-base unit of the integer field formatter: one digit per step.
// Decimal uses a registered reciprocal multiply; hex is a shift. Uses ifmt_pkg.
module ifmt_div_unit (
   input  logic                           clock,
   input  logic                           mul_en,  // load product for current dividend
   input  logic                           hex,
   input  logic [31:0]                    mag,
   output ifmt_pkg::div_result_type       result
);

   logic [63:0] prod_ff;
   logic [63:0] prod_in;
   logic [31:0] quot_dec;
   logic [31:0] quot_x10;

   // Reciprocal multiply, registered before use
   assign prod_in = {32'd0, mag} * {32'd0, ifmt_pkg::RECIP_TEN};

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // Quotient and remainder from the registered product
   assign quot_dec = {3'd0, prod_ff[63:ifmt_pkg::RECIP_SHIFT]};
   assign quot_x10 = {quot_dec[28:0], 3'd0} + {quot_dec[30:0], 1'b0};

   always_comb begin
      if (hex) begin
         result.quot  = {4'd0, mag[31:4]};
         result.digit = mag[3:0];
      end else begin
         result.quot  = quot_dec;
         result.digit = 4'((mag - quot_x10));
      end
   end

endmodule

@@ hw/rtl/integer_field_formatter.sv @@
// Top level of the integer field formatter: sequencer, digit store and output.
// Depends on ifmt_pkg and ifmt_div_unit.

// One request is formatted as a printf-style %d or %x field and sent out as one
// character per item, tlast on the final one. A request is taken only when the
// block is idle. Digits come from one shared divide unit: a reciprocal multiply,
// then quotient and remainder, for each decimal digit, and a shift for each hex
// digit, up to ten digits for decimal and eight for hex. After the digits the
// padding is sized; then the characters are sent in order while the output
// register is free, up to 63 characters. A request that yields an empty field
// (zero, precision zero, width zero) produces no item.
module integer_field_formatter (
   input  logic        clock,
   input  logic        reset,
   // Request: tdata = value[31:0], field_width[37:32], has_prec[38], prec[44:39]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic [0:0]  req_tuser,   // func[0]
   // Result: tdata = ch[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIG  = 3'd2;
   localparam logic [2:0] ST_FIN  = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic        hex_ff, hex_in;
   logic [31:0] mag_ff, mag_in;
   logic [5:0]  width_ff, width_in;
   logic        hp_ff, hp_in;
   logic [5:0]  prec_ff, prec_in;
   logic        zero_ff, zero_in;
   logic        sign_ff, sign_in;
   logic [3:0]  count_ff, count_in;
   logic [5:0]  zeros_ff, zeros_in;
   logic [5:0]  spaces_ff, spaces_in;
   logic [5:0]  total_ff, total_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_ch_ff, rsp_ch_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [3:0]  digit_store [ifmt_pkg::DIGIT_DEPTH];
   logic        store_we;

   ifmt_pkg::div_result_type div_res;
   logic        slot_free;
   logic        req_fire;
   logic [3:0]  fin_count;
   logic [5:0]  fin_zeros;
   logic [6:0]  fin_len;
   logic [5:0]  fin_spaces;
   logic [3:0]  rd_idx;
   logic [5:0]  req_prec;

   ifmt_div_unit u_div (
      .clock  (clock),
      .mul_en (state_ff == ST_MUL),
      .hex    (hex_ff),
      .mag    (mag_ff),
      .result (div_res)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rd_idx     = count_ff - 4'd1;
   assign req_prec   = (req_tdata[44:39] > ifmt_pkg::MAX_PREC) ? ifmt_pkg::MAX_PREC
                                                               : req_tdata[44:39];

   // Padding sizes once the digits are known
   assign fin_count  = (zero_ff && hp_ff && prec_ff == 6'd0) ? 4'd0 : count_ff;
   assign fin_zeros  = (prec_ff > {2'd0, fin_count}) ? (prec_ff - {2'd0, fin_count}) : 6'd0;
   assign fin_len    = {6'd0, sign_ff} + {1'b0, fin_zeros} + {3'd0, fin_count};
   assign fin_spaces = ({1'b0, width_ff} > fin_len) ? 6'(({1'b0, width_ff} - fin_len))
                                                    : 6'd0;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      hex_in       = hex_ff;
      mag_in       = mag_ff;
      width_in     = width_ff;
      hp_in        = hp_ff;
      prec_in      = prec_ff;
      zero_in      = zero_ff;
      sign_in      = sign_ff;
      count_in     = count_ff;
      zeros_in     = zeros_ff;
      spaces_in    = spaces_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ch_in    = rsp_ch_ff;
      rsp_last_in  = rsp_last_ff;
      store_we     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               hex_in   = (req_tuser[0] == ifmt_pkg::FUNC_HEX);
               sign_in  = (req_tuser[0] == ifmt_pkg::FUNC_DEC) && req_tdata[31];
               mag_in   = sign_in ? (32'd0 - req_tdata[31:0]) : req_tdata[31:0];
               width_in = req_tdata[37:32];
               hp_in    = req_tdata[38];
               prec_in  = req_tdata[38] ? req_prec : 6'd0;
               zero_in  = (req_tdata[31:0] == 32'd0);
               count_in = 4'd0;
               state_in = hex_in ? ST_DIG : ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_DIG;
         end
         ST_DIG: begin
            store_we = 1'b1;
            count_in = count_ff + 4'd1;
            mag_in   = div_res.quot;
            if (div_res.quot == 32'd0) begin
               state_in = ST_FIN;
            end else begin
               state_in = hex_ff ? ST_DIG : ST_MUL;
            end
         end
         ST_FIN: begin
            count_in  = fin_count;
            zeros_in  = fin_zeros;
            spaces_in = fin_spaces;
            total_in  = 6'(fin_len + {1'b0, fin_spaces});
            state_in  = (total_in == 6'd0) ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = (total_ff == 6'd1);
               total_in     = total_ff - 6'd1;
               if (spaces_ff != 6'd0) begin
                  rsp_ch_in = ifmt_pkg::CHAR_SPACE;
                  spaces_in = spaces_ff - 6'd1;
               end else if (sign_ff) begin
                  rsp_ch_in = ifmt_pkg::CHAR_MINUS;
                  sign_in   = 1'b0;
               end else if (zeros_ff != 6'd0) begin
                  rsp_ch_in = ifmt_pkg::CHAR_ZERO;
                  zeros_in  = zeros_ff - 6'd1;
               end else begin
                  rsp_ch_in = ifmt_pkg::digit_char(digit_store[rd_idx]);
                  count_in  = count_ff - 4'd1;
               end
               if (total_ff == 6'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sign_ff      <= 1'b0;
         count_ff     <= 4'd0;
         zeros_ff     <= 6'd0;
         spaces_ff    <= 6'd0;
         total_ff     <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sign_ff      <= sign_in;
         count_ff     <= count_in;
         zeros_ff     <= zeros_in;
         spaces_ff    <= spaces_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      hex_ff      <= hex_in;
      mag_ff      <= mag_in;
      width_ff    <= width_in;
      hp_ff       <= hp_in;
      prec_ff     <= prec_in;
      zero_ff     <= zero_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Digit store, least significant digit first
   always_ff @(posedge clock) begin
      if (store_we) begin
         digit_store[count_ff] <= div_res.digit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ch_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // Digit store never overflows: at most ten digits
   a_store_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIG) |-> (count_ff < 4'd10))
      else $error("digit store overrun");

   // A request is taken only from idle, and work starts next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("ready while converting");

   // Remaining field length matches the pending pieces
   a_total_consistent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |->
      ({1'b0, total_ff} == ({1'b0, spaces_ff} + {6'd0, sign_ff} + {1'b0, zeros_ff}
                            + {3'd0, count_ff})))
      else $error("field length mismatch");
`endif

endmodule

@@ tb/ifmt_field_checker.sv @@
// Scoreboard for the integer field formatter: watches the request and
// character streams, predicts each formatted field and compares it.
// Depends on ifmt_pkg for character codes, kinds and the precision cap.
module ifmt_field_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,    // value[31:0], field_width[37:32], has_prec[38], prec[44:39]
   input  logic [0:0]  req_tuser,    // func[0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,    // ch[7:0]
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          chars_pending,
   output int          requests_seen,
   output int          chars_seen
);

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } field_char_type;

   field_char_type expected_chars[$];
   int             mismatches = 0;

   assign fail_count = mismatches;

   task automatic report_mismatch(input string msg);
      begin
         $display("[%0t] MISMATCH: %s", $realtime, msg);
         mismatches++;
      end
   endtask

   // Build the whole field for one request and queue its characters
   task automatic format_field(input logic func, input logic [31:0] value,
                               input logic [5:0] width, input logic has_prec,
                               input logic [5:0] prec_raw);
      logic [3:0]     digits[0:10];
      logic [7:0]     text[$];
      logic [31:0]    mag;
      logic           neg;
      int             prec;
      int             ndig;
      int             nzero;
      int             nspace;
      int             len;
      field_char_type item;
      begin
         prec = (prec_raw > ifmt_pkg::MAX_PREC) ? int'(ifmt_pkg::MAX_PREC) : int'(prec_raw);
         if (!has_prec) prec = 0;
         neg = (func == ifmt_pkg::FUNC_DEC) && value[31];
         // unsigned negate gives the right magnitude for the most negative value too
         mag = neg ? (32'd0 - value) : value;
         ndig = 0;
         do begin
            if (func == ifmt_pkg::FUNC_HEX) begin
               digits[ndig] = mag[3:0];
               mag = mag >> 4;
            end else begin
               digits[ndig] = 4'(mag % 32'd10);
               mag = mag / 32'd10;
            end
            ndig++;
         end while (mag != 0);
         // zero with an explicit zero precision prints no digit
         if (value == 0 && has_prec && prec == 0) ndig = 0;
         nzero  = (prec > ndig) ? prec - ndig : 0;
         len    = int'(neg) + nzero + ndig;
         nspace = (int'(width) > len) ? int'(width) - len : 0;
         for (int i = 0; i < nspace; i++) text.push_back(ifmt_pkg::CHAR_SPACE);
         if (neg) text.push_back(ifmt_pkg::CHAR_MINUS);
         for (int i = 0; i < nzero; i++) text.push_back(ifmt_pkg::CHAR_ZERO);
         for (int i = ndig - 1; i >= 0; i--) begin
            if (digits[i] < 4'd10) text.push_back(ifmt_pkg::CHAR_ZERO + {4'd0, digits[i]});
            else text.push_back(ifmt_pkg::CHAR_A + {4'd0, digits[i]} - 8'd10);
         end
         foreach (text[i]) begin
            item.ch   = text[i];
            item.last = (i == text.size() - 1);
            expected_chars.push_back(item);
         end
      end
   endtask

   // Sample both channels at the clock edge
   always @(posedge clock) begin
      field_char_type exp_item;
      if (reset) begin
         chars_pending <= 0;
         requests_seen <= 0;
         chars_seen    <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            format_field(req_tuser[0], req_tdata[31:0], req_tdata[37:32], req_tdata[38],
                         req_tdata[44:39]);
            requests_seen <= requests_seen + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            chars_seen <= chars_seen + 1;
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected item ch=%02h last=%0b",
                                         rsp_tdata, rsp_tlast));
            end else begin
               exp_item = expected_chars.pop_front();
               if (rsp_tdata !== exp_item.ch)
                  report_mismatch($sformatf("ch got %02h expected %02h",
                                            rsp_tdata, exp_item.ch));
               if (rsp_tlast !== exp_item.last)
                  report_mismatch($sformatf("last got %0b expected %0b on ch %02h",
                                            rsp_tlast, exp_item.last, exp_item.ch));
            end
         end
         chars_pending <= expected_chars.size();
      end
   end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for integer_field_formatter: clock, reset, request stimulus,
// output back-pressure and the verdict. Depends on ifmt_pkg and ifmt_field_checker.
module tb_top;

   localparam int CLOCK_PERIOD = 8;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 120;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;     // value[31:0], field_width[37:32], has_prec[38], prec[44:39]
   logic [0:0]  req_tuser  = '0;     // func[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;           // ch[7:0]
   logic        rsp_tlast;

   int tx_idle_pct    = 0;
   int rx_idle_pct    = 0;
   int cycle_count    = 0;
   int directed_count = 0;
   int fail_count;
   int chars_pending;
   int requests_seen;
   int chars_seen;

   integer_field_formatter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   ifmt_field_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .chars_pending (chars_pending),
      .requests_seen (requests_seen),
      .chars_seen    (chars_seen)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items outstanding", cycle_count,
                  chars_pending);
         $display("** integer_field_formatter: FAILED **");
         $finish;
      end
   end

   // Offer one request, with random idle cycles ahead of it
   task automatic send_request(input logic func, input logic [31:0] value,
                               input logic [5:0] width, input logic has_prec,
                               input logic [5:0] prec);
      begin
         while ($urandom_range(99) < tx_idle_pct) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= {3'b000, prec, has_prec, width, value};
         req_tuser  <= func;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
   endtask

   // Hold off until every queued character has been seen
   task automatic wait_drained();
      begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while (chars_pending != 0);
      end
   endtask

   function automatic logic [31:0] rand_value();
      logic [31:0] v;
      begin
         case ($urandom_range(5))
            0: v = $urandom();
            1: v = $urandom_range(15);
            2: v = $urandom_range(99999);
            3: begin
               case ($urandom_range(3))
                  0: v = 32'h8000_0000;
                  1: v = 32'hFFFF_FFFF;
                  2: v = 32'h7FFF_FFFF;
                  default: v = 32'd0;
               endcase
            end
            4: v = 32'd0 - $urandom_range(1000, 1);
            default: v = $urandom() >> $urandom_range(31);
         endcase
         return v;
      end
   endfunction

   // Mostly short sizes, a quarter over the full range
   function automatic logic [5:0] rand_size();
      begin
         if ($urandom_range(3) == 0) return 6'($urandom_range(63));
         return 6'($urandom_range(12));
      end
   endfunction

   task automatic send_random(input int count);
      begin
         for (int i = 0; i < count; i++) begin
            send_request($urandom_range(1) ? ifmt_pkg::FUNC_HEX : ifmt_pkg::FUNC_DEC,
                         rand_value(), rand_size(), 1'($urandom_range(1)), rand_size());
         end
      end
   endtask

   task automatic send_directed();
      begin
         // zero in both kinds, with no precision, an explicit zero precision and a nonzero one
         send_request(ifmt_pkg::FUNC_DEC, 32'd0, 6'd0, 1'b0, 6'd0);
         send_request(ifmt_pkg::FUNC_DEC, 32'd0, 6'd0, 1'b1, 6'd0);
         send_request(ifmt_pkg::FUNC_DEC, 32'd0, 6'd5, 1'b1, 6'd0);
         send_request(ifmt_pkg::FUNC_HEX, 32'd0, 6'd0, 1'b0, 6'd0);
         send_request(ifmt_pkg::FUNC_HEX, 32'd0, 6'd0, 1'b1, 6'd0);
         send_request(ifmt_pkg::FUNC_HEX, 32'd0, 6'd63, 1'b1, 6'd0);
         send_request(ifmt_pkg::FUNC_DEC, 32'd0, 6'd0, 1'b1, 6'd1);
         send_request(ifmt_pkg::FUNC_HEX, 32'd0, 6'd0, 1'b1, 6'd63);
         // most negative and other extremes
         send_request(ifmt_pkg::FUNC_DEC, 32'h8000_0000, 6'd0, 1'b0, 6'd0);
         send_request(ifmt_pkg::FUNC_DEC, 32'h8000_0000, 6'd63, 1'b1, 6'd63);
         send_request(ifmt_pkg::FUNC_DEC, 32'h7FFF_FFFF, 6'd11, 1'b0, 6'd0);
         send_request(ifmt_pkg::FUNC_DEC, 32'hFFFF_FFFF, 6'd10, 1'b1, 6'd5);
         send_request(ifmt_pkg::FUNC_HEX, 32'hFFFF_FFFF, 6'd63, 1'b1, 6'd63);
         send_request(ifmt_pkg::FUNC_HEX, 32'h8000_0000, 6'd0, 1'b1, 6'd62);
         send_request(ifmt_pkg::FUNC_HEX, 32'hDEAD_BEEF, 6'd9, 1'b0, 6'd0);
         // width narrower than the digits, a precision that is ignored, and large precisions
         send_request(ifmt_pkg::FUNC_DEC, 32'd12345, 6'd3, 1'b0, 6'd0);
         send_request(ifmt_pkg::FUNC_HEX, 32'h0000_000A, 6'd63, 1'b0, 6'd40);
         send_request(ifmt_pkg::FUNC_DEC, 32'd0 - 32'd42, 6'd63, 1'b1, 6'd62);
         send_request(ifmt_pkg::FUNC_DEC, 32'd1_000_000_000, 6'd0, 1'b1, 6'd10);
         send_request(ifmt_pkg::FUNC_DEC, 32'd7, 6'd63, 1'b1, 6'd62);
         directed_count = 20;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // slow sender, heavy back-pressure
      tx_idle_pct = 32;
      rx_idle_pct = 78;
      send_directed();
      send_random(160);
      wait_drained();

      // sender mostly idle, light back-pressure
      tx_idle_pct = 78;
      rx_idle_pct = 32;
      send_random(170);

      // full rate both ways
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      send_random(170);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests (%0d directed) and %0d characters", requests_seen,
               directed_count, chars_seen);
      $display("under three sender/receiver idle mixes, %0d mismatches", fail_count);
      if (fail_count == 0) begin
         $display("** integer_field_formatter: PASSED **");
      end else begin
         $display("** integer_field_formatter: FAILED **");
      end
      $finish;
   end

endmodule
